// ===== rtl/ica_pkg.sv =====
`default_nettype none

package ica_pkg;

   // Default arithmetic width
   localparam int DATA_WIDTH_DEFAULT = 64;

   // Port field widths
   localparam int OPERAND_WIDTH = 64;
   localparam int OP_WIDTH      = 3;
   localparam int STATUS_WIDTH  = 2;

   // Digit width of the shared multiplier (multiplicand times one digit)
   localparam int DIGIT_WIDTH = 8;

   // Operation codes
   localparam logic [OP_WIDTH-1:0] OP_ADD  = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB  = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL  = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV  = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_REM  = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_FACT = 3'd5;

   // Status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_INVALID  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_NEG_FACT = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic done;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== rtl/ica_ctrl.sv =====
`default_nettype none

module ica_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire ica_pkg::dp_sts_type sts,
   output ica_pkg::ctrl_cmd_type   cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_BUSY = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Sequence one item: load, iterate until done, present the result
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (sts.done) begin
               cmd.finish = 1'b1;
               state_in   = S_RESP;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ica_dpath.sv =====
`default_nettype none

module ica_dpath #(
   parameter int DATA_WIDTH = ica_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire ica_pkg::ctrl_cmd_type               cmd,
   output ica_pkg::dp_sts_type                      sts,
   input  wire logic [ica_pkg::OP_WIDTH-1:0]        req_operation,
   input  wire logic [ica_pkg::OPERAND_WIDTH-1:0]   req_operand_a,
   input  wire logic [ica_pkg::OPERAND_WIDTH-1:0]   req_operand_b,
   output logic      [ica_pkg::OPERAND_WIDTH-1:0]   rsp_result_value,
   output logic      [ica_pkg::STATUS_WIDTH-1:0]    rsp_status
);

   localparam int W         = DATA_WIDTH;
   localparam int DW        = ica_pkg::DIGIT_WIDTH;
   localparam int CNT_W     = $clog2(W + 1);
   localparam int MUL_STEPS = (W + DW - 1) / DW;
   // n! is zero modulo 2^W well before this bound
   localparam int FACT_LIMIT = 2 * W + 2;

   logic [ica_pkg::OP_WIDTH-1:0] op_ff;
   logic [W-1:0]                 a_ff;
   logic [W-1:0]                 b_ff;
   logic [W-1:0]                 acc_ff, acc_in;
   logic [W-1:0]                 x_ff, x_in;
   logic [W-1:0]                 y_ff, y_in;
   logic [W-1:0]                 rem_ff, rem_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [DW-1:0]                idx_ff, idx_in;
   logic [ica_pkg::OPERAND_WIDTH-1:0] res_ff, res_in;
   logic [ica_pkg::STATUS_WIDTH-1:0]  st_ff, st_in;

   logic [W-1:0]     ld_a;
   logic [W-1:0]     ld_b;
   logic [W-1:0]     ld_mag_a;
   logic [W-1:0]     ld_mag_b;
   logic             a_neg;
   logic             b_neg;
   logic             b_zero;
   logic             fact_big;
   logic [DW-1:0]    fact_n;
   logic [W-1:0]     mul_x;
   logic [DW-1:0]    mul_d;
   logic [W+DW-1:0]  prod;
   logic [W:0]       shifted;
   logic [W:0]       diff;
   logic [W-1:0]     res_w;

   // Take the operands at the datapath width
   assign ld_a     = req_operand_a[W-1:0];
   assign ld_b     = req_operand_b[W-1:0];
   assign ld_mag_a = ld_a[W-1] ? (~ld_a + W'(1)) : ld_a;
   assign ld_mag_b = ld_b[W-1] ? (~ld_b + W'(1)) : ld_b;

   assign a_neg    = a_ff[W-1];
   assign b_neg    = b_ff[W-1];
   assign b_zero   = (b_ff == '0);
   assign fact_big = (a_ff > W'(FACT_LIMIT));
   assign fact_n   = a_ff[DW-1:0];

   // Shared multiplier: W-bit value times one digit
   assign mul_x = (op_ff == ica_pkg::OP_FACT) ? acc_ff : x_ff;
   assign mul_d = (op_ff == ica_pkg::OP_FACT) ? idx_ff : y_ff[DW-1:0];
   assign prod  = {{DW{1'b0}}, mul_x} * {{W{1'b0}}, mul_d};

   // One restoring divide step
   assign shifted = {rem_ff, acc_ff[W-1]};
   assign diff    = shifted - {1'b0, x_ff};

   // Report when the current item needs no more steps
   always_comb begin
      sts.done = 1'b1;
      case (op_ff)
         ica_pkg::OP_MUL: begin
            sts.done = (cnt_ff == CNT_W'(MUL_STEPS));
         end
         ica_pkg::OP_DIV, ica_pkg::OP_REM: begin
            sts.done = b_zero || (cnt_ff == CNT_W'(W));
         end
         ica_pkg::OP_FACT: begin
            sts.done = a_neg || fact_big || (idx_ff > fact_n) || (acc_ff == '0);
         end
         default: begin
            sts.done = 1'b1;
         end
      endcase
   end

   // Load the work registers or advance one step
   always_comb begin
      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         acc_in = '0;
         x_in   = ld_a;
         y_in   = ld_b;
         rem_in = '0;
         cnt_in = '0;
         idx_in = DW'(2);
         if (req_operation inside {ica_pkg::OP_DIV, ica_pkg::OP_REM}) begin
            acc_in = ld_mag_a;
            x_in   = ld_mag_b;
         end else if (req_operation == ica_pkg::OP_FACT) begin
            acc_in = W'(1);
         end
      end else if (cmd.step) begin
         case (op_ff)
            ica_pkg::OP_MUL: begin
               acc_in = acc_ff + prod[W-1:0];
               x_in   = x_ff << DW;
               y_in   = y_ff >> DW;
               cnt_in = cnt_ff + CNT_W'(1);
            end
            ica_pkg::OP_DIV, ica_pkg::OP_REM: begin
               if (!diff[W]) begin
                  rem_in = diff[W-1:0];
                  acc_in = {acc_ff[W-2:0], 1'b1};
               end else begin
                  rem_in = shifted[W-1:0];
                  acc_in = {acc_ff[W-2:0], 1'b0};
               end
               cnt_in = cnt_ff + CNT_W'(1);
            end
            ica_pkg::OP_FACT: begin
               acc_in = prod[W-1:0];
               idx_in = idx_ff + DW'(1);
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   // Form the result and status of the finished item
   always_comb begin
      res_w = '0;
      st_in = ica_pkg::ST_OK;
      case (op_ff)
         ica_pkg::OP_ADD: begin
            res_w = a_ff + b_ff;
         end
         ica_pkg::OP_SUB: begin
            res_w = a_ff - b_ff;
         end
         ica_pkg::OP_MUL: begin
            res_w = acc_ff;
         end
         ica_pkg::OP_DIV: begin
            if (b_zero) begin
               st_in = ica_pkg::ST_DIV_ZERO;
            end else begin
               res_w = (a_neg != b_neg) ? (~acc_ff + W'(1)) : acc_ff;
            end
         end
         ica_pkg::OP_REM: begin
            if (b_zero) begin
               st_in = ica_pkg::ST_DIV_ZERO;
            end else begin
               res_w = a_neg ? (~rem_ff + W'(1)) : rem_ff;
            end
         end
         ica_pkg::OP_FACT: begin
            if (a_neg) begin
               st_in = ica_pkg::ST_NEG_FACT;
            end else if (!fact_big) begin
               res_w = acc_ff;
            end
         end
         default: begin
            st_in = ica_pkg::ST_INVALID;
         end
      endcase
      if (st_in != ica_pkg::ST_OK) begin
         res_w = '0;
      end
      res_in = ica_pkg::OPERAND_WIDTH'(signed'(res_w));
   end

   // Hold operands and work registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         a_ff  <= ld_a;
         b_ff  <= ld_b;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      if (cmd.finish) begin
         res_ff <= res_in;
         st_ff  <= st_in;
      end
   end

   assign rsp_result_value = res_ff;
   assign rsp_status       = st_ff;

endmodule

`default_nettype wire

// ===== rtl/integer_calculator_alu.sv =====
// Signed integer ALU: add, subtract, multiply, divide, remainder, factorial.
// Input channel req_*: one item is an operation code and two signed operands,
// taken when req_valid is high and req_stall is low. Result channel rsp_*:
// one item per input, a signed result and a status, taken when rsp_valid is
// high and rsp_stall is low.
// One item is worked on at a time; req_stall stays high from acceptance until
// the result has been taken. Work per item after acceptance:
//   add, subtract, errors, invalid codes: no iterative steps
//   multiply: one 8-bit digit per cycle
//   divide, remainder: one quotient bit a cycle
//   factorial of n: one factor a cycle, until all factors up to n are in
//     or the product wraps to zero
// The shared DATA_WIDTH by 8 multiplier and the restoring divide step do the
// iterative work. The next item is accepted in the cycle after the result is
// taken. While rsp_stall is high the result holds and no item is accepted.
// Reset returns the controller to idle; no result is pending afterwards.
`default_nettype none

module integer_calculator_alu #(
   parameter int DATA_WIDTH = ica_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ica_pkg::OP_WIDTH-1:0]      req_operation,
   input  wire logic [ica_pkg::OPERAND_WIDTH-1:0] req_operand_a,
   input  wire logic [ica_pkg::OPERAND_WIDTH-1:0] req_operand_b,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [ica_pkg::OPERAND_WIDTH-1:0] rsp_result_value,
   output logic      [ica_pkg::STATUS_WIDTH-1:0]  rsp_status
);

   ica_pkg::ctrl_cmd_type cmd;
   ica_pkg::dp_sts_type   sts;

   // Sequence each item
   ica_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Compute the result
   ica_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;

   // Codes outside the operation set
   localparam logic [ica_pkg::OP_WIDTH-1:0] OP_INVALID_LO = 3'd6;
   localparam logic [ica_pkg::OP_WIDTH-1:0] OP_INVALID_HI = 3'd7;

   localparam logic [ica_pkg::OPERAND_WIDTH-1:0] MOST_NEG  = 64'h8000_0000_0000_0000;
   localparam logic [ica_pkg::OPERAND_WIDTH-1:0] MOST_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [ica_pkg::OPERAND_WIDTH-1:0] MINUS_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

   // Past this many factors the product is surely zero
   localparam int FACT_BOUND     = 130;
   localparam int RANDOM_PER_SET = 142;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [ica_pkg::OPERAND_WIDTH-1:0] value;
      logic [ica_pkg::STATUS_WIDTH-1:0]  status;
   } alu_answer_type;

   typedef struct packed {
      logic [ica_pkg::OP_WIDTH-1:0]      op;
      logic [ica_pkg::OPERAND_WIDTH-1:0] a;
      logic [ica_pkg::OPERAND_WIDTH-1:0] b;
      logic                              known;
      logic [ica_pkg::OPERAND_WIDTH-1:0] value;
      logic [ica_pkg::STATUS_WIDTH-1:0]  status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ica_pkg::OP_WIDTH-1:0] req_operation = ica_pkg::OP_ADD;
   logic [ica_pkg::OPERAND_WIDTH-1:0] req_operand_a = '0;
   logic [ica_pkg::OPERAND_WIDTH-1:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ica_pkg::OPERAND_WIDTH-1:0] rsp_result_value;
   logic [ica_pkg::STATUS_WIDTH-1:0] rsp_status;

   alu_answer_type offered_answer = '0;
   alu_answer_type pending_answers [$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fault_count = 0;
   int idle_cycles = 0;
   int holdoff_left = 0;
   logic holdoff_req = 1'b0;
   logic holdoff_used = 1'b0;

   // Directed items: extremes, every operation, each corner case
   stim_row_type directed_rows [25] = '{
      '{ica_pkg::OP_ADD, MOST_POS, 64'd1, 1'b1, MOST_NEG, ica_pkg::ST_OK},
      '{ica_pkg::OP_SUB, MOST_NEG, 64'd1, 1'b1, MOST_POS, ica_pkg::ST_OK},
      '{ica_pkg::OP_ADD, MINUS_ONE, MINUS_ONE, 1'b0, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_SUB, 64'd0, MOST_NEG, 1'b1, MOST_NEG, ica_pkg::ST_OK},
      '{ica_pkg::OP_MUL, MOST_POS, MOST_POS, 1'b0, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_MUL, MOST_NEG, MINUS_ONE, 1'b1, MOST_NEG, ica_pkg::ST_OK},
      '{ica_pkg::OP_MUL, -64'd12345, 64'd6789, 1'b0, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_DIV, MOST_POS, 64'd0, 1'b1, 64'd0, ica_pkg::ST_DIV_ZERO},
      '{ica_pkg::OP_REM, MOST_NEG, 64'd0, 1'b1, 64'd0, ica_pkg::ST_DIV_ZERO},
      '{ica_pkg::OP_DIV, MOST_NEG, MINUS_ONE, 1'b1, MOST_NEG, ica_pkg::ST_OK},
      '{ica_pkg::OP_REM, MOST_NEG, MINUS_ONE, 1'b1, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_DIV, -64'd7, 64'd2, 1'b0, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_REM, -64'd7, 64'd2, 1'b0, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_DIV, 64'd7, -64'd2, 1'b0, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_REM, 64'd7, -64'd2, 1'b0, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_DIV, MOST_NEG, MOST_POS, 1'b0, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_FACT, MINUS_ONE, 64'd0, 1'b1, 64'd0, ica_pkg::ST_NEG_FACT},
      '{ica_pkg::OP_FACT, MOST_NEG, MOST_POS, 1'b1, 64'd0, ica_pkg::ST_NEG_FACT},
      '{ica_pkg::OP_FACT, 64'd0, MINUS_ONE, 1'b1, 64'd1, ica_pkg::ST_OK},
      '{ica_pkg::OP_FACT, 64'd20, 64'd0, 1'b0, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_FACT, 64'd65, 64'd0, 1'b0, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_FACT, 64'd66, 64'd0, 1'b1, 64'd0, ica_pkg::ST_OK},
      '{ica_pkg::OP_FACT, MOST_POS, 64'd0, 1'b1, 64'd0, ica_pkg::ST_OK},
      '{OP_INVALID_LO, 64'd5, 64'd3, 1'b1, 64'd0, ica_pkg::ST_INVALID},
      '{OP_INVALID_HI, MOST_NEG, MINUS_ONE, 1'b1, 64'd0, ica_pkg::ST_INVALID}
   };

   integer_calculator_alu uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Compute the result and status of one operation
   function automatic alu_answer_type calc_answer(
      input logic [ica_pkg::OP_WIDTH-1:0]      op,
      input logic [ica_pkg::OPERAND_WIDTH-1:0] a,
      input logic [ica_pkg::OPERAND_WIDTH-1:0] b);
      alu_answer_type ans;
      logic [ica_pkg::OPERAND_WIDTH-1:0] mag_a;
      logic [ica_pkg::OPERAND_WIDTH-1:0] mag_b;
      logic [ica_pkg::OPERAND_WIDTH-1:0] acc;
      int unsigned k;
      ans.value = '0;
      ans.status = ica_pkg::ST_OK;
      mag_a = a[ica_pkg::OPERAND_WIDTH-1] ? -a : a;
      mag_b = b[ica_pkg::OPERAND_WIDTH-1] ? -b : b;
      case (op)
         ica_pkg::OP_ADD: ans.value = a + b;
         ica_pkg::OP_SUB: ans.value = a - b;
         ica_pkg::OP_MUL: ans.value = a * b;
         ica_pkg::OP_DIV, ica_pkg::OP_REM: begin
            if (b == '0) begin
               ans.status = ica_pkg::ST_DIV_ZERO;
            end else if (op == ica_pkg::OP_DIV) begin
               acc = mag_a / mag_b;
               ans.value = (a[ica_pkg::OPERAND_WIDTH-1] ^ b[ica_pkg::OPERAND_WIDTH-1]) ?
                           -acc : acc;
            end else begin
               acc = mag_a % mag_b;
               ans.value = a[ica_pkg::OPERAND_WIDTH-1] ? -acc : acc;
            end
         end
         ica_pkg::OP_FACT: begin
            if (a[ica_pkg::OPERAND_WIDTH-1]) begin
               ans.status = ica_pkg::ST_NEG_FACT;
            end else begin
               // multiply up to a, or until the product wraps to zero
               acc = 64'd1;
               for (k = 2; k <= FACT_BOUND && k <= a && acc != '0; k++)
                  acc = acc * k;
               ans.value = (a > FACT_BOUND) ? '0 : acc;
            end
         end
         default: ans.status = ica_pkg::ST_INVALID;
      endcase
      return ans;
   endfunction

   // Draw an operand: full range, corners, or narrow values of either sign
   function automatic logic [ica_pkg::OPERAND_WIDTH-1:0] pick_operand();
      logic [ica_pkg::OPERAND_WIDTH-1:0] v;
      int sel;
      sel = $urandom_range(0, 7);
      case (sel)
         0, 1, 2: v = {$urandom, $urandom};
         3: begin
            case ($urandom_range(0, 5))
               0: v = MOST_NEG;
               1: v = MOST_POS;
               2: v = MINUS_ONE;
               3: v = '0;
               4: v = 64'd1;
               default: v = MOST_NEG + 64'd1;
            endcase
         end
         4, 5: v = 64'($urandom_range(0, 1000));
         default: v = {$urandom, $urandom} >> $urandom_range(1, 63);
      endcase
      if (sel >= 4 && $urandom_range(0, 1) == 1)
         v = -v;
      return v;
   endfunction

   task automatic make_random_item(output logic [ica_pkg::OP_WIDTH-1:0] op,
                                   output logic [ica_pkg::OPERAND_WIDTH-1:0] a,
                                   output logic [ica_pkg::OPERAND_WIDTH-1:0] b);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) op = ica_pkg::OP_ADD;
      else if (pick < 6) op = ica_pkg::OP_SUB;
      else if (pick < 9) op = ica_pkg::OP_MUL;
      else if (pick < 12) op = ica_pkg::OP_DIV;
      else if (pick < 15) op = ica_pkg::OP_REM;
      else if (pick < 18) op = ica_pkg::OP_FACT;
      else if (pick == 18) op = OP_INVALID_LO;
      else op = OP_INVALID_HI;
      a = pick_operand();
      b = pick_operand();
      // favor zero divisors and factorial arguments around the wrap point
      if ((op == ica_pkg::OP_DIV || op == ica_pkg::OP_REM) && $urandom_range(0, 7) == 0)
         b = '0;
      if (op == ica_pkg::OP_FACT && $urandom_range(0, 3) != 0)
         a = 64'($urandom_range(0, 70));
   endtask

   // Offer one item, with random idle cycles first, and hold it until taken
   task automatic send_item(input logic [ica_pkg::OP_WIDTH-1:0] op,
                            input logic [ica_pkg::OPERAND_WIDTH-1:0] a,
                            input logic [ica_pkg::OPERAND_WIDTH-1:0] b,
                            input alu_answer_type ans);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      offered_answer <= ans;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic note_fault(input string msg);
      if (fault_count < REPORT_LIMIT)
         $display("%s", msg);
      fault_count++;
   endtask

   // Receiver: random stall, plus one long hold-off on request
   always @(posedge clock) begin
      if (holdoff_req && !holdoff_used) begin
         holdoff_used <= 1'b1;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Queue expectations on accepted items, check taken results, watch for hangs
   always @(posedge clock) begin : result_check
      alu_answer_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_answers.push_back(offered_answer);
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               note_fault($sformatf("unexpected result: value %h, code %0d",
                                    rsp_result_value, rsp_status));
            end else begin
               want = pending_answers.pop_front();
               if (rsp_result_value !== want.value)
                  note_fault($sformatf("rsp_result_value mismatch: expected %h, got %h",
                                       want.value, rsp_result_value));
               if (rsp_status !== want.status)
                  note_fault($sformatf("rsp_status mismatch: expected %0d, got %0d",
                                       want.status, rsp_status));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      alu_answer_type ans;
      logic [ica_pkg::OP_WIDTH-1:0] op;
      logic [ica_pkg::OPERAND_WIDTH-1:0] a;
      logic [ica_pkg::OPERAND_WIDTH-1:0] b;
      int set_idx;
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 8;
      recv_idle_pct <= 72;

      // Directed items: take the typed answer where one is given
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.known) begin
            ans.value = row.value;
            ans.status = row.status;
         end else begin
            ans = calc_answer(row.op, row.a, row.b);
         end
         send_item(row.op, row.a, row.b, ans);
      end

      // Random items: sender-light, receiver-light, then no random idling but one long receiver hold-off
      for (set_idx = 0; set_idx < 3; set_idx++) begin
         case (set_idx)
            0: begin
               send_idle_pct = 8;
               recv_idle_pct <= 72;
            end
            1: begin
               send_idle_pct = 72;
               recv_idle_pct <= 8;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
               holdoff_req <= 1'b1;
            end
         endcase
         for (n = 0; n < RANDOM_PER_SET; n++) begin
            make_random_item(op, a, b);
            send_item(op, a, b, calc_answer(op, a, b));
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every result, then idle before reporting the verdict
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/ica_pkg.sv
rtl/ica_ctrl.sv
rtl/ica_dpath.sv
rtl/integer_calculator_alu.sv
bench/tb.sv
